@@ rtl/wvnd_pkg.sv @@
// ----------------------------------------------------------------------------
// Warped value noise density package
// Shared widths, fixed-point constants and arithmetic helpers for the grove
// density pipeline and its value-noise and band-scale units.
// ----------------------------------------------------------------------------
package wvnd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TILE_W    = 24;
   localparam int COORD_W   = 36;
   localparam int CELL_W    = COORD_W - FRAC_BITS;
   localparam int NOISE_LAT = 6;

   // Lattice hash constants.
   localparam logic [63:0] HASH_MUL_X  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] HASH_MUL_Y  = 64'hC2B2_AE3D_27D4_EB4F;
   localparam logic [63:0] HASH_MIX    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] SALT_WARP_X = 64'h51;
   localparam logic [63:0] SALT_WARP_Y = 64'h52;
   localparam logic [63:0] SALT_OCT2   = 64'hA3;

   // Tile to lattice scaling: x = tile * 624 + floor((32 * tile + 105) / 210).
   localparam logic [9:0]  TILE_WHOLE = 10'd624;
   localparam logic [29:0] DIV_BIAS   = 30'd440402025;
   localparam int          DIV_SHIFT  = 38;
   localparam logic [30:0] RECIP_210  = 31'(((64'd1 << DIV_SHIFT) + 64'd209) / 64'd210);
   localparam logic [COORD_W-1:0] DIV_OFFSET = COORD_W'(2097152);

   // Q.16 coefficients.
   localparam logic [16:0] C_WARP_SCALE  = 17'd39322;
   localparam logic [16:0] C_WARP_GAIN   = 17'd72090;
   localparam logic [17:0] C_OCT2_SCALE  = 18'd137626;
   localparam logic [15:0] C_OCT1_WEIGHT = 16'd42598;
   localparam logic [15:0] C_OCT2_WEIGHT = 16'd22938;

   // Lattice offsets in Q.16.
   localparam logic [COORD_W-1:0] OFS_WX_X   = COORD_W'(203162);
   localparam logic [COORD_W-1:0] OFS_WX_Y   = COORD_W'(111411);
   localparam logic [COORD_W-1:0] OFS_WY_X   = COORD_W'(340787);
   localparam logic [COORD_W-1:0] OFS_WY_Y   = COORD_W'(609485);
   localparam logic [COORD_W-1:0] OFS_OCT2_X = COORD_W'(720896);
   localparam logic [COORD_W-1:0] OFS_OCT2_Y = COORD_W'(458752);

   // Band edges and output scaling.
   localparam logic [15:0] GLADE_LO    = 16'd13107;
   localparam logic [15:0] GLADE_HI    = 16'd27525;
   localparam logic [15:0] THICK_LO    = 16'd45875;
   localparam logic [15:0] THICK_HI    = 16'd58982;
   localparam logic [15:0] GLADE_FLOOR = 16'd7864;
   localparam logic [15:0] GLADE_RANGE = 16'd57672;
   localparam logic [15:0] THICK_TIGHT = 16'd29491;

   localparam int BAND_SHIFT  = 44;
   localparam int BAND_DIFF_W = 14;
   localparam logic [30:0] GLADE_RECIP =
      31'(((64'd1 << BAND_SHIFT) + 64'(GLADE_HI - GLADE_LO) - 64'd1) / 64'(GLADE_HI - GLADE_LO));
   localparam logic [30:0] THICK_RECIP =
      31'(((64'd1 << BAND_SHIFT) + 64'(THICK_HI - THICK_LO) - 64'd1) / 64'(THICK_HI - THICK_LO));

   localparam logic [15:0] BAND_LO    [2] = '{GLADE_LO, THICK_LO};
   localparam logic [15:0] BAND_HI    [2] = '{GLADE_HI, THICK_HI};
   localparam logic [30:0] BAND_RECIP [2] = '{GLADE_RECIP, THICK_RECIP};

   // A lattice sample point handed to a noise unit.
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   // First half of smoothstep: floor(t * t / 2^16).
   function automatic logic [16:0] smooth_sq(input logic [16:0] t);
      logic [33:0] p;
      p = t * t;
      return p[32:16];
   endfunction

   // Second half of smoothstep: floor(t2 * (3 * 2^16 - 2 * t) / 2^16).
   function automatic logic [16:0] smooth_fin(input logic [16:0] t2, input logic [16:0] t);
      logic [34:0] p;
      p = t2 * (18'h30000 - {t, 1'b0});
      return p[32:16];
   endfunction

   // Linear blend of two Q0.16 values by weight s.
   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] s);
      logic [32:0] acc;
      acc = a * (17'h10000 - s) + b * s;
      return acc[31:16];
   endfunction

endpackage

@@ rtl/wvnd_noise.sv @@
// ----------------------------------------------------------------------------
// Value noise unit
// Six-stage pipeline: lattice cell and smoothstep, four 64-bit corner
// hashes, then a bilinear blend of the hashed values.
// ----------------------------------------------------------------------------
module wvnd_noise (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         seed,
   input  wvnd_pkg::point_type pt,
   output logic                out_valid,
   output logic [15:0]         out_value
);

   logic [wvnd_pkg::NOISE_LAT-1:0] vld_ff;

   // Stage 1
   logic [wvnd_pkg::CELL_W-1:0] cx, cy;
   logic signed [52:0] xlo_in, ylo_in, xlo_ff, ylo_ff;
   logic [31:0]        xhi_in, yhi_in, xhi_ff, yhi_ff;
   logic [15:0]        fx_ff, fy_ff;
   logic [16:0]        t2x_ff, t2y_ff;

   // Stage 2
   logic [63:0] a0_in, b0_in;
   logic [63:0] a0_ff, a1_ff, b0_ff, b1_ff;
   logic [16:0] sx2_ff, sy2_ff;

   // Stage 3
   logic [63:0] hc [4];
   logic [63:0] mc [4];
   logic [63:0] pll_in [4];
   logic [31:0] crs_in [4];
   logic [63:0] pll_ff [4];
   logic [31:0] crs_ff [4];
   logic [16:0] sx3_ff, sy3_ff;

   // Stage 4
   logic [63:0] hm [4];
   logic [15:0] hash_in [4];
   logic [15:0] hash_ff [4];
   logic [16:0] sx4_ff, sy4_ff;

   // Stage 5 and 6
   logic [15:0] r0_ff, r1_ff, val_ff;
   logic [16:0] sy5_ff;

   assign cx = pt.x[wvnd_pkg::COORD_W-1:wvnd_pkg::FRAC_BITS];
   assign cy = pt.y[wvnd_pkg::COORD_W-1:wvnd_pkg::FRAC_BITS];

   // The cell index times the hash constant is split into two 32-bit halves.
   assign xlo_in = $signed(cx) * $signed({1'b0, wvnd_pkg::HASH_MUL_X[31:0]});
   assign ylo_in = $signed(cy) * $signed({1'b0, wvnd_pkg::HASH_MUL_Y[31:0]});
   assign xhi_in = 32'($signed(cx)) * wvnd_pkg::HASH_MUL_X[63:32];
   assign yhi_in = 32'($signed(cy)) * wvnd_pkg::HASH_MUL_Y[63:32];

   assign a0_in = 64'(xlo_ff) + {xhi_ff, 32'd0};
   assign b0_in = 64'(ylo_ff) + {yhi_ff, 32'd0};

   always_comb begin
      hc[0] = seed ^ a0_ff ^ b0_ff;
      hc[1] = seed ^ a1_ff ^ b0_ff;
      hc[2] = seed ^ a0_ff ^ b1_ff;
      hc[3] = seed ^ a1_ff ^ b1_ff;
      for (int i = 0; i < 4; i++) begin
         mc[i]     = hc[i] ^ (hc[i] >> 29);
         pll_in[i] = mc[i][31:0] * wvnd_pkg::HASH_MIX[31:0];
         crs_in[i] = mc[i][31:0] * wvnd_pkg::HASH_MIX[63:32]
                   + mc[i][63:32] * wvnd_pkg::HASH_MIX[31:0];
         hm[i]      = pll_ff[i] + {crs_ff[i], 32'd0};
         // The final xor with the upper half leaves the top 16 bits as they are.
         hash_in[i] = hm[i][63:48];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[wvnd_pkg::NOISE_LAT-2:0], pt.valid};
      end
   end

   always_ff @(posedge clock) begin
      xlo_ff <= xlo_in;
      ylo_ff <= ylo_in;
      xhi_ff <= xhi_in;
      yhi_ff <= yhi_in;
      fx_ff  <= pt.x[wvnd_pkg::FRAC_BITS-1:0];
      fy_ff  <= pt.y[wvnd_pkg::FRAC_BITS-1:0];
      t2x_ff <= wvnd_pkg::smooth_sq({1'b0, pt.x[wvnd_pkg::FRAC_BITS-1:0]});
      t2y_ff <= wvnd_pkg::smooth_sq({1'b0, pt.y[wvnd_pkg::FRAC_BITS-1:0]});

      a0_ff  <= a0_in;
      a1_ff  <= a0_in + wvnd_pkg::HASH_MUL_X;
      b0_ff  <= b0_in;
      b1_ff  <= b0_in + wvnd_pkg::HASH_MUL_Y;
      sx2_ff <= wvnd_pkg::smooth_fin(t2x_ff, {1'b0, fx_ff});
      sy2_ff <= wvnd_pkg::smooth_fin(t2y_ff, {1'b0, fy_ff});

      for (int i = 0; i < 4; i++) begin
         pll_ff[i]  <= pll_in[i];
         crs_ff[i]  <= crs_in[i];
         hash_ff[i] <= hash_in[i];
      end
      sx3_ff <= sx2_ff;
      sy3_ff <= sy2_ff;
      sx4_ff <= sx3_ff;
      sy4_ff <= sy3_ff;

      r0_ff  <= wvnd_pkg::blend(hash_ff[0], hash_ff[1], sx4_ff);
      r1_ff  <= wvnd_pkg::blend(hash_ff[2], hash_ff[3], sx4_ff);
      sy5_ff <= sy4_ff;
      val_ff <= wvnd_pkg::blend(r0_ff, r1_ff, sy5_ff);
   end

   assign out_valid = vld_ff[wvnd_pkg::NOISE_LAT-1];
   assign out_value = val_ff;

   // A sample leaves exactly the fixed latency after it entered.
   a_noise_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(pt.valid, wvnd_pkg::NOISE_LAT))
      else $error("noise sample left without a matching entry");

endmodule

@@ rtl/wvnd_band.sv @@
// ----------------------------------------------------------------------------
// Band scale unit
// Maps a grove level to the glade chance scale and the thicket spacing
// scale through two smoothstep bands, in five pipeline stages.
// ----------------------------------------------------------------------------
module wvnd_band (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] in_level,
   output logic        out_valid,
   output logic [15:0] out_level,
   output logic [16:0] out_glade,
   output logic [16:0] out_thicket
);

   localparam int LAT = 5;

   typedef enum logic [1:0] {POS_BELOW, POS_INSIDE, POS_ABOVE} band_pos_type;

   logic [LAT-1:0] vld_ff;
   logic [15:0]    lvl_ff [LAT];

   band_pos_type pos_in [2];
   band_pos_type pos_ff [2];
   logic [15:0]  diff_in [2];
   logic [44:0]  qprod_in [2];
   logic [44:0]  qprod_ff [2];
   logic [16:0]  t_in [2];
   logic [16:0]  t_ff [2];
   logic [16:0]  t2_ff [2];
   logic [16:0]  s_ff [2];
   logic [32:0]  gm_ff, tm_ff;
   logic [16:0]  glade_ff, thick_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         diff_in[i] = in_level - wvnd_pkg::BAND_LO[i];
         if (in_level <= wvnd_pkg::BAND_LO[i]) begin
            pos_in[i] = POS_BELOW;
         end else if (in_level >= wvnd_pkg::BAND_HI[i]) begin
            pos_in[i] = POS_ABOVE;
         end else begin
            pos_in[i] = POS_INSIDE;
         end
         // Division by the band width as a reciprocal multiply.
         qprod_in[i] = diff_in[i][wvnd_pkg::BAND_DIFF_W-1:0] * wvnd_pkg::BAND_RECIP[i];
         case (pos_ff[i])
            POS_BELOW:  t_in[i] = 17'd0;
            POS_ABOVE:  t_in[i] = 17'h10000;
            POS_INSIDE: t_in[i] = {1'b0, qprod_ff[i][wvnd_pkg::BAND_SHIFT-1:28]};
            default:    t_in[i] = 17'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff[0] <= in_level;
      for (int k = 1; k < LAT; k++) begin
         lvl_ff[k] <= lvl_ff[k-1];
      end
      for (int i = 0; i < 2; i++) begin
         pos_ff[i]   <= pos_in[i];
         qprod_ff[i] <= qprod_in[i];
         t_ff[i]     <= t_in[i];
         t2_ff[i]    <= wvnd_pkg::smooth_sq(t_in[i]);
         s_ff[i]     <= wvnd_pkg::smooth_fin(t2_ff[i], t_ff[i]);
      end
      gm_ff    <= s_ff[0] * wvnd_pkg::GLADE_RANGE + 33'd32768;
      tm_ff    <= s_ff[1] * wvnd_pkg::THICK_TIGHT + 33'd32768;
      glade_ff <= 17'(wvnd_pkg::GLADE_FLOOR) + gm_ff[32:16];
      thick_ff <= 17'h10000 - tm_ff[32:16];
   end

   assign out_valid   = vld_ff[LAT-1];
   assign out_level   = lvl_ff[LAT-1];
   assign out_glade   = glade_ff;
   assign out_thicket = thick_ff;

   a_glade_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_level <= wvnd_pkg::GLADE_LO) |->
         out_glade == 17'(wvnd_pkg::GLADE_FLOOR))
      else $error("glade scale above floor below the glade band");

   a_glade_full: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_level >= wvnd_pkg::GLADE_HI) |-> out_glade == 17'h10000)
      else $error("glade scale not full above the glade band");

   a_thicket_core: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_level >= wvnd_pkg::THICK_HI) |->
         out_thicket == 17'h10000 - 17'(wvnd_pkg::THICK_TIGHT))
      else $error("thicket scale not tightest in a thicket core");

endmodule

@@ rtl/warped_value_noise_density.sv @@
// ----------------------------------------------------------------------------
// Warped value noise density
// Grove density field from a domain-warped, two-octave value noise, with
// the glade spawn scale and thicket spacing scale derived from it.
// ----------------------------------------------------------------------------
// Usage:
// The block takes one tile coordinate pair per transfer on req_tile_x and
// req_tile_y; a transfer happens at a clock edge with start high and busy
// low. busy is always low, so a new tile can be sent in every cycle.
// Each tile gives exactly one result: rsp_valid is high for one cycle with
// rsp_grove_level, rsp_glade_chance_scale and rsp_thicket_spacing_scale.
// The throughput is one tile per cycle. The pipeline is made up of the
// coordinate front end (4 stages), two value-noise passes of 6 stages
// each, the warp and octave-scale stages (4), the octave sum (1) and the
// band-scale stages (5). The receiver cannot hold results off, and none is
// needed: the pipeline never stalls.
// The 64-bit world seed is written through csr_wr_en and csr_wr_data while
// no tile is in flight. Synchronous reset clears the seed to zero and
// empties the pipeline; tiles in flight at reset are dropped.
// ----------------------------------------------------------------------------
module warped_value_noise_density (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_tile_x,
   input  logic [23:0] req_tile_y,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_grove_level,
   output logic [16:0] rsp_glade_chance_scale,
   output logic [16:0] rsp_thicket_spacing_scale
);

   localparam int CW = wvnd_pkg::COORD_W;

   logic [63:0] seed_ff;
   logic        accept;

   // Front end: tile to lattice units, then the warp sample points.
   logic              fv1_ff, fv2_ff, fv3_ff;
   logic [29:0]       ux_in, uy_in;
   logic [60:0]       qpx_in, qpy_in, qpx_ff, qpy_ff;
   logic signed [34:0] tix_in, tiy_in, tix_ff, tiy_ff;
   logic [CW-1:0]     x2_in, y2_in, x2_ff, y2_ff;
   logic signed [52:0] wpx_in, wpy_in, wpx_ff, wpy_ff;
   logic [CW-1:0]     x3_ff, y3_ff, x4_ff, y4_ff;
   logic [52:0]       wsx, wsy;
   wvnd_pkg::point_type pta_in, ptb_in, pta_ff, ptb_ff;
   logic [CW-1:0]     xd_ff [wvnd_pkg::NOISE_LAT];
   logic [CW-1:0]     yd_ff [wvnd_pkg::NOISE_LAT];

   // Warp noise results.
   logic        nwx_valid, nwy_valid;
   logic [15:0] nwx, nwy;

   // Warp and second octave coordinates.
   logic [2:0]         wv_ff;
   logic signed [34:0] wmx_in, wmy_in, wmx_ff, wmy_ff;
   logic [CW-1:0]      xw1_ff, yw1_ff, xw_ff, yw_ff, xw3_ff, yw3_ff;
   logic [34:0]        wrx, wry;
   logic signed [54:0] opx_in, opy_in, opx_ff, opy_ff;
   logic [54:0]        osx, osy;
   wvnd_pkg::point_type pt1_in, pt2_in, pt1_ff, pt2_ff;

   // Octave results and sum.
   logic        n1_valid, n2_valid;
   logic [15:0] n1, n2;
   logic [32:0] gsum;
   logic        gv_ff;
   logic [15:0] g_ff;

   // Results leave in every cycle if need be, so the input side never waits.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // Scaling by 1/105 with round to nearest: the whole part of 2^16/105 is
   // a small multiply, and the remainder term is divided by 210 through a
   // reciprocal multiply on a value biased to be non-negative.
   assign ux_in  = 30'($signed({req_tile_x, 5'd0})) + wvnd_pkg::DIV_BIAS;
   assign uy_in  = 30'($signed({req_tile_y, 5'd0})) + wvnd_pkg::DIV_BIAS;
   assign qpx_in = ux_in * wvnd_pkg::RECIP_210;
   assign qpy_in = uy_in * wvnd_pkg::RECIP_210;
   assign tix_in = $signed(req_tile_x) * $signed({1'b0, wvnd_pkg::TILE_WHOLE});
   assign tiy_in = $signed(req_tile_y) * $signed({1'b0, wvnd_pkg::TILE_WHOLE});

   assign x2_in = CW'(tix_ff) + CW'(qpx_ff[60:wvnd_pkg::DIV_SHIFT]) - wvnd_pkg::DIV_OFFSET;
   assign y2_in = CW'(tiy_ff) + CW'(qpy_ff[60:wvnd_pkg::DIV_SHIFT]) - wvnd_pkg::DIV_OFFSET;

   // Warp sample points are taken at 0.6 times the lattice point.
   assign wpx_in = $signed(x2_ff) * $signed({1'b0, wvnd_pkg::C_WARP_SCALE});
   assign wpy_in = $signed(y2_ff) * $signed({1'b0, wvnd_pkg::C_WARP_SCALE});
   assign wsx    = wpx_ff + 53'd32768;
   assign wsy    = wpy_ff + 53'd32768;

   always_comb begin
      pta_in.valid = fv3_ff;
      pta_in.x     = wsx[CW+15:16] + wvnd_pkg::OFS_WX_X;
      pta_in.y     = wsy[CW+15:16] + wvnd_pkg::OFS_WX_Y;
      ptb_in.valid = fv3_ff;
      ptb_in.x     = wsx[CW+15:16] + wvnd_pkg::OFS_WY_X;
      ptb_in.y     = wsy[CW+15:16] + wvnd_pkg::OFS_WY_Y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv1_ff       <= 1'b0;
         fv2_ff       <= 1'b0;
         fv3_ff       <= 1'b0;
         pta_ff.valid <= 1'b0;
         ptb_ff.valid <= 1'b0;
      end else begin
         fv1_ff <= accept;
         fv2_ff <= fv1_ff;
         fv3_ff <= fv2_ff;
         pta_ff <= pta_in;
         ptb_ff <= ptb_in;
      end
   end

   always_ff @(posedge clock) begin
      qpx_ff <= qpx_in;
      qpy_ff <= qpy_in;
      tix_ff <= tix_in;
      tiy_ff <= tiy_in;
      x2_ff  <= x2_in;
      y2_ff  <= y2_in;
      wpx_ff <= wpx_in;
      wpy_ff <= wpy_in;
      x3_ff  <= x2_ff;
      y3_ff  <= y2_ff;
      x4_ff  <= x3_ff;
      y4_ff  <= y3_ff;
      // The lattice point waits here while the warp noise is evaluated.
      xd_ff[0] <= x4_ff;
      yd_ff[0] <= y4_ff;
      for (int k = 1; k < wvnd_pkg::NOISE_LAT; k++) begin
         xd_ff[k] <= xd_ff[k-1];
         yd_ff[k] <= yd_ff[k-1];
      end
   end

   wvnd_noise u_noise_wx (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff ^ wvnd_pkg::SALT_WARP_X),
      .pt        (pta_ff),
      .out_valid (nwx_valid),
      .out_value (nwx)
   );

   wvnd_noise u_noise_wy (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff ^ wvnd_pkg::SALT_WARP_Y),
      .pt        (ptb_ff),
      .out_valid (nwy_valid),
      .out_value (nwy)
   );

   // The warp shift is (noise - 0.5) times the gain of 1.1, rounded.
   assign wmx_in = $signed({1'b0, nwx} - 17'd32768) * $signed({1'b0, wvnd_pkg::C_WARP_GAIN});
   assign wmy_in = $signed({1'b0, nwy} - 17'd32768) * $signed({1'b0, wvnd_pkg::C_WARP_GAIN});
   assign wrx    = wmx_ff + 35'd32768;
   assign wry    = wmy_ff + 35'd32768;

   // The second octave runs at 2.1 times the warped point plus an offset.
   assign opx_in = $signed(xw_ff) * $signed({1'b0, wvnd_pkg::C_OCT2_SCALE});
   assign opy_in = $signed(yw_ff) * $signed({1'b0, wvnd_pkg::C_OCT2_SCALE});
   assign osx    = opx_ff + 55'd32768;
   assign osy    = opy_ff + 55'd32768;

   always_comb begin
      pt1_in.valid = wv_ff[2];
      pt1_in.x     = xw3_ff;
      pt1_in.y     = yw3_ff;
      pt2_in.valid = wv_ff[2];
      pt2_in.x     = osx[CW+15:16] + wvnd_pkg::OFS_OCT2_X;
      pt2_in.y     = osy[CW+15:16] + wvnd_pkg::OFS_OCT2_Y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff        <= '0;
         pt1_ff.valid <= 1'b0;
         pt2_ff.valid <= 1'b0;
      end else begin
         wv_ff  <= {wv_ff[1:0], nwx_valid && nwy_valid};
         pt1_ff <= pt1_in;
         pt2_ff <= pt2_in;
      end
   end

   always_ff @(posedge clock) begin
      wmx_ff <= wmx_in;
      wmy_ff <= wmy_in;
      xw1_ff <= xd_ff[wvnd_pkg::NOISE_LAT-1];
      yw1_ff <= yd_ff[wvnd_pkg::NOISE_LAT-1];
      xw_ff  <= xw1_ff + CW'($signed(wrx[34:16]));
      yw_ff  <= yw1_ff + CW'($signed(wry[34:16]));
      opx_ff <= opx_in;
      opy_ff <= opy_in;
      xw3_ff <= xw_ff;
      yw3_ff <= yw_ff;
   end

   wvnd_noise u_noise_oct1 (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .pt        (pt1_ff),
      .out_valid (n1_valid),
      .out_value (n1)
   );

   wvnd_noise u_noise_oct2 (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff ^ wvnd_pkg::SALT_OCT2),
      .pt        (pt2_ff),
      .out_valid (n2_valid),
      .out_value (n2)
   );

   // Octave weights 0.65 and 0.35, rounded; the sum is held below one.
   assign gsum = n1 * wvnd_pkg::C_OCT1_WEIGHT + n2 * wvnd_pkg::C_OCT2_WEIGHT + 33'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff <= 1'b0;
      end else begin
         gv_ff <= n1_valid && n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= gsum[32] ? 16'hFFFF : gsum[31:16];
   end

   wvnd_band u_band (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (gv_ff),
      .in_level    (g_ff),
      .out_valid   (rsp_valid),
      .out_level   (rsp_grove_level),
      .out_glade   (rsp_glade_chance_scale),
      .out_thicket (rsp_thicket_spacing_scale)
   );

endmodule

@@ dv/tb_warped_value_noise_density.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warped value noise density testbench
// Sends tile coordinate pairs under several world seeds and checks every
// result against a cycle-free predictor of the grove density pipeline.
// ----------------------------------------------------------------------------
module tb_warped_value_noise_density;

   // Pipeline depth from the block header, with margin for draining.
   localparam int LATENCY    = 26;
   localparam int DRAIN_WAIT = LATENCY + 10;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic [23:0] tile_x;
      logic [23:0] tile_y;
   } tile_type;

   typedef struct {
      logic [15:0] grove;
      logic [16:0] glade;
      logic [16:0] thicket;
   } density_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [23:0] req_tile_x;
   logic [23:0] req_tile_y;
   logic        csr_wr_en;
   logic [63:0] csr_wr_data;
   logic        rsp_valid;
   logic [15:0] rsp_grove_level;
   logic [16:0] rsp_glade_chance_scale;
   logic [16:0] rsp_thicket_spacing_scale;

   warped_value_noise_density dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_tile_x                (req_tile_x),
      .req_tile_y                (req_tile_y),
      .csr_wr_en                 (csr_wr_en),
      .csr_wr_data               (csr_wr_data),
      .rsp_valid                 (rsp_valid),
      .rsp_grove_level           (rsp_grove_level),
      .rsp_glade_chance_scale    (rsp_glade_chance_scale),
      .rsp_thicket_spacing_scale (rsp_thicket_spacing_scale)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Seed held by the predictor; it follows every register write.
   logic [63:0] seed_model;

   tile_type    tile_queue[$];
   density_type density_queue[$];
   int          error_count;
   int          result_count;
   int          seed_count;
   bit          quiet_driver;

   // ------------------------------------------------------------------------
   // Predictor arithmetic. All values are carried as signed 64-bit integers;
   // coordinates stay far below the range where that could overflow.
   // ------------------------------------------------------------------------
   function automatic longint floor_quot(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // Round to nearest with ties toward +infinity.
   function automatic longint near_quot(input longint n, input longint d);
      return floor_quot(2 * n + d, 2 * d);
   endfunction

   function automatic longint coef_mul(input longint a, input longint c);
      return near_quot(a * c, 64'sd65536);
   endfunction

   function automatic longint tenths_to_lattice(input longint tenths);
      return near_quot(tenths * (64'sd1 <<< wvnd_pkg::FRAC_BITS), 64'sd10);
   endfunction

   function automatic logic [15:0] cell_hash(input longint ix, input longint iy,
                                             input logic [63:0] seed);
      logic [63:0] h;
      h = seed;
      h = h ^ (64'(ix) * wvnd_pkg::HASH_MUL_X);
      h = h ^ (64'(iy) * wvnd_pkg::HASH_MUL_Y);
      h = h ^ (h >> 29);
      h = h * wvnd_pkg::HASH_MIX;
      h = h ^ (h >> 32);
      return h[63:48];
   endfunction

   function automatic longint ease(input longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * (3 * 65536 - 2 * t)) >>> 16;
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint s);
      return (a * (65536 - s) + b * s) >>> 16;
   endfunction

   function automatic longint lattice_noise(input longint px, input longint py,
                                            input logic [63:0] seed);
      longint unit_len, x0, y0, sx, sy, top, bot;
      unit_len = 64'sd1 <<< wvnd_pkg::FRAC_BITS;
      x0 = floor_quot(px, unit_len);
      y0 = floor_quot(py, unit_len);
      // FRAC_BITS is 16, so the cell fraction is already Q0.16.
      sx = ease(px - x0 * unit_len);
      sy = ease(py - y0 * unit_len);
      top = mix(cell_hash(x0, y0, seed), cell_hash(x0 + 1, y0, seed), sx);
      bot = mix(cell_hash(x0, y0 + 1, seed), cell_hash(x0 + 1, y0 + 1, seed), sx);
      return mix(top, bot, sy);
   endfunction

   function automatic longint warp_offset(input longint n);
      return near_quot((n - 32768) * longint'(wvnd_pkg::C_WARP_GAIN),
                       64'sd1 <<< (32 - wvnd_pkg::FRAC_BITS));
   endfunction

   function automatic longint band_ease(input longint g, input longint lo, input longint hi);
      longint t;
      if (g <= lo) t = 0;
      else if (g >= hi) t = 65536;
      else t = ((g - lo) << 16) / (hi - lo);
      return ease(t);
   endfunction

   function automatic density_type predict_density(input tile_type tile,
                                                   input logic [63:0] seed);
      longint      x, y, wx, wy, nwx, nwy, n1, n2, g, s;
      density_type d;
      x = near_quot(longint'($signed(tile.tile_x)) * 65536, 64'sd105);
      y = near_quot(longint'($signed(tile.tile_y)) * 65536, 64'sd105);
      wx = coef_mul(x, wvnd_pkg::C_WARP_SCALE);
      wy = coef_mul(y, wvnd_pkg::C_WARP_SCALE);
      nwx = lattice_noise(wx + tenths_to_lattice(31), wy + tenths_to_lattice(17),
                          seed ^ wvnd_pkg::SALT_WARP_X);
      nwy = lattice_noise(wx + tenths_to_lattice(52), wy + tenths_to_lattice(93),
                          seed ^ wvnd_pkg::SALT_WARP_Y);
      x = x + warp_offset(nwx);
      y = y + warp_offset(nwy);
      n1 = lattice_noise(x, y, seed);
      n2 = lattice_noise(coef_mul(x, wvnd_pkg::C_OCT2_SCALE) + tenths_to_lattice(110),
                         coef_mul(y, wvnd_pkg::C_OCT2_SCALE) + tenths_to_lattice(70),
                         seed ^ wvnd_pkg::SALT_OCT2);
      g = (longint'(wvnd_pkg::C_OCT1_WEIGHT) * n1
           + longint'(wvnd_pkg::C_OCT2_WEIGHT) * n2 + 32768) >>> 16;
      if (g > 65535) g = 65535;
      d.grove = g[15:0];
      s = band_ease(g, wvnd_pkg::GLADE_LO, wvnd_pkg::GLADE_HI);
      d.glade = 17'(longint'(wvnd_pkg::GLADE_FLOOR)
                    + ((longint'(wvnd_pkg::GLADE_RANGE) * s + 32768) >>> 16));
      s = band_ease(g, wvnd_pkg::THICK_LO, wvnd_pkg::THICK_HI);
      d.thicket = 17'(65536 - ((longint'(wvnd_pkg::THICK_TIGHT) * s + 32768) >>> 16));
      return d;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents queued tiles and idles about a quarter of the time,
   // except in the quiet stretch when it sends back to back.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         req_tile_x <= '0;
         req_tile_y <= '0;
      end else begin
         // A tile on the ports is taken by the edge that just passed.
         if (start && !busy) begin
            density_queue.insert(density_queue.size(),
                                 predict_density(tile_queue.pop_front(), seed_model));
         end
         if (tile_queue.size() > 0 && (quiet_driver || $urandom_range(99) >= 26)) begin
            start      <= 1'b1;
            req_tile_x <= tile_queue[0].tile_x;
            req_tile_y <= tile_queue[0].tile_y;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: each strobe is a result transfer, checked against the oldest
   // prediction field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      density_type want;
      if (!reset && rsp_valid) begin
         if (density_queue.size() == 0) begin
            $error("unexpected result: grove %0d", rsp_grove_level);
            error_count++;
         end else begin
            want = density_queue.pop_front();
            result_count++;
            if (rsp_grove_level !== want.grove) begin
               $error("grove_level: expected %0d, got %0d", want.grove, rsp_grove_level);
               error_count++;
            end
            if (rsp_glade_chance_scale !== want.glade) begin
               $error("glade_chance_scale: expected %0d, got %0d",
                      want.glade, rsp_glade_chance_scale);
               error_count++;
            end
            if (rsp_thicket_spacing_scale !== want.thicket) begin
               $error("thicket_spacing_scale: expected %0d, got %0d",
                      want.thicket, rsp_thicket_spacing_scale);
               error_count++;
            end
         end
      end
   end

   // Queues a tile from two signed coordinates.
   task automatic add_tile(input logic [23:0] tx, input logic [23:0] ty);
      tile_type t;
      t.tile_x = tx;
      t.tile_y = ty;
      tile_queue.insert(tile_queue.size(), t);
   endtask

   // Random coordinate: mostly near the origin where the fractions vary
   // finely, sometimes across the full 24-bit range.
   function automatic logic [23:0] random_coord();
      if ($urandom_range(3) == 0) return 24'($urandom);
      return 24'($signed($urandom_range(4000)) - 2000);
   endfunction

   // Waits for the pipeline to drain, then idles for the DRAIN_WAIT margin.
   task automatic drain();
      while (tile_queue.size() > 0 || start || density_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Writes the seed register while nothing is in flight.
   task automatic write_seed(input logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      seed_model  = value;
      csr_wr_en   <= 1'b0;
      seed_count++;
   endtask

   initial begin
      logic [63:0] seeds[5];
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      seed_model   = '0;
      error_count  = 0;
      result_count = 0;
      seed_count   = 0;
      quiet_driver = 1'b0;
      reset        = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed tiles under the reset seed: the origin, the extremes of
      // both axes, sign crossings and the ends of the lattice scaling.
      add_tile(24'd0, 24'd0);
      add_tile(24'h7FFFFF, 24'h7FFFFF);
      add_tile(24'h800000, 24'h800000);
      add_tile(24'h7FFFFF, 24'h800000);
      add_tile(24'h800000, 24'h7FFFFF);
      add_tile(24'hFFFFFF, 24'd1);
      add_tile(24'd1, 24'hFFFFFF);
      add_tile(24'd105, 24'hFFFF97);
      add_tile(24'd52, 24'd53);
      add_tile(24'hFFFFCC, 24'hFFFFCB);
      add_tile(24'h555555, 24'hAAAAAA);
      add_tile(24'hAAAAAA, 24'h555555);
      drain();

      // Seeds include both extremes and alternating bit patterns. Each seed
      // gets a sweep of random tiles; the quiet stretch runs with no gaps.
      seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA,
                {$urandom, $urandom}, {$urandom, $urandom}};
      for (int k = 0; k < 5; k++) begin
         write_seed(seeds[k]);
         quiet_driver = (k == 2);
         add_tile(24'h7FFFFF, 24'h800000);
         for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            add_tile(random_coord(), random_coord());
         drain();
      end

      $display("Covered %0d results over %0d seed settings, including full-range",
               result_count, seed_count);
      $display("coordinates and gap-free tile bursts.");
      if (error_count == 0) begin
         $display("warped_value_noise_density regression: pass");
      end else begin
         $display("warped_value_noise_density regression: fail");
      end
      $finish;
   end

   // Generous limit for the 517 tiles with gaps and the drains between them.
   initial begin
      #2ms;
      $display("warped_value_noise_density regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/wvnd_pkg.sv
rtl/wvnd_noise.sv
rtl/wvnd_band.sv
rtl/warped_value_noise_density.sv
dv/tb_warped_value_noise_density.sv
